// ===== src/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stereo peak meter ballistics block.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned COEF_W  = 16;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic        [COEF_W-1:0]  coef_t;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_FLOOR_LEVEL   = 2'd0,
        REG_CLIP_THRESH   = 2'd1,
        REG_PEAK_COEF     = 2'd2,
        REG_DISPLAY_COEF  = 2'd3
    } reg_index_t;

    // item kinds
    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_CLEAR = 1'b1
    } kind_t;

    localparam level_t FLOOR_RESET        = -16'sd15360;
    localparam level_t CLIP_THRESH_RESET  = 16'sd0;
    localparam coef_t  PEAK_COEF_RESET    = 16'd1311;
    localparam coef_t  DISPLAY_COEF_RESET = 16'd6554;

    // clip release hysteresis: 0.5 dB in 1/256 dB
    localparam logic signed [LEVEL_W:0] CLIP_RELEASE = 17'sd128;

    typedef struct packed {
        level_t floor_level;
        level_t clip_threshold;
        coef_t  peak_decay_coef;
        coef_t  display_decay_coef;
    } meter_cfg_t;

    typedef struct packed {
        level_t shown;
        level_t peak;
        logic   clip;
    } chan_state_t;

endpackage

// ===== src/stereo_peak_meter_ballistics.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_meter_ballistics
// Two-channel peak-hold level meter with exponential decay of the held
// peak and of the displayed level, and a clip indicator per channel.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid/in_ready, kind, left/right_level | in
//  out     | out_valid/out_ready, *_shown, *_peak, *_clip | out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
//  An item is held in the input register and is then evaluated against
//  the meter state, which doubles as the result register; one multiply
//  and clamp per decay unit set the path. Throughput is 1 item per cycle
//  while the result is not stalled. Reset loads the default registers and
//  puts the meter at the floor. A stalled result holds both stages.
// ----------------------------------------------------------------------------
module stereo_peak_meter_ballistics
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  spm_pkg::level_t       left_level,
    input  spm_pkg::level_t       right_level,

    output logic                  out_valid,
    input  logic                  out_ready,
    output spm_pkg::level_t       left_shown,
    output spm_pkg::level_t       right_shown,
    output spm_pkg::level_t       left_peak,
    output spm_pkg::level_t       right_peak,
    output logic                  left_clip,
    output logic                  right_clip,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    spm_pkg::meter_cfg_t  cfg_reg;
    spm_pkg::meter_cfg_t  cfg_next;

    logic                 s1_valid_reg;
    spm_pkg::kind_t       s1_kind_reg;
    spm_pkg::level_t      s1_left_reg;
    spm_pkg::level_t      s1_right_reg;

    logic                 out_valid_reg;
    spm_pkg::chan_state_t left_reg;
    spm_pkg::chan_state_t right_reg;
    spm_pkg::chan_state_t left_next;
    spm_pkg::chan_state_t right_next;

    logic                 advance;
    logic                 fire;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign fire      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (spm_pkg::reg_index_t'(cfg_index))
                spm_pkg::REG_FLOOR_LEVEL:  cfg_next.floor_level        = cfg_data;
                spm_pkg::REG_CLIP_THRESH:  cfg_next.clip_threshold     = cfg_data;
                spm_pkg::REG_PEAK_COEF:    cfg_next.peak_decay_coef    = cfg_data;
                spm_pkg::REG_DISPLAY_COEF: cfg_next.display_decay_coef = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_level        <= spm_pkg::FLOOR_RESET;
            cfg_reg.clip_threshold     <= spm_pkg::CLIP_THRESH_RESET;
            cfg_reg.peak_decay_coef    <= spm_pkg::PEAK_COEF_RESET;
            cfg_reg.display_decay_coef <= spm_pkg::DISPLAY_COEF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg  <= spm_pkg::kind_t'(kind);
            s1_left_reg  <= left_level;
            s1_right_reg <= right_level;
        end
    end

    spm_channel u_left
    (
        .kind  (s1_kind_reg),
        .level (s1_left_reg),
        .cfg   (cfg_reg),
        .cur   (left_reg),
        .nxt   (left_next)
    );

    spm_channel u_right
    (
        .kind  (s1_kind_reg),
        .level (s1_right_reg),
        .cfg   (cfg_reg),
        .cur   (right_reg),
        .nxt   (right_next)
    );

    // meter state, presented directly as the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            left_reg.shown  <= spm_pkg::FLOOR_RESET;
            left_reg.peak   <= spm_pkg::FLOOR_RESET;
            left_reg.clip   <= 1'b0;
            right_reg.shown <= spm_pkg::FLOOR_RESET;
            right_reg.peak  <= spm_pkg::FLOOR_RESET;
            right_reg.clip  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_shown  = left_reg.shown;
    assign right_shown = right_reg.shown;
    assign left_peak   = left_reg.peak;
    assign right_peak  = right_reg.peak;
    assign left_clip   = left_reg.clip;
    assign right_clip  = right_reg.clip;

`ifndef NO_ASSERTIONS
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_kind_reg == spm_pkg::KIND_CLEAR
        |=> !left_clip && !right_clip && left_peak == left_shown
            && right_peak == right_shown)
        else $error("clear item left clip or state off the floor");

    a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("evaluated item did not reach the result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(left_reg) && $stable(right_reg))
        else $error("meter state moved without an item");
`endif

endmodule

// ===== src/spm_decay.sv =====
// ----------------------------------------------------------------------------
// spm_decay
// Moves a level toward the floor by a Q0.16 fraction of its distance,
// rounding the step down and clamping at the floor.
// ----------------------------------------------------------------------------
module spm_decay
(
    input  spm_pkg::level_t value,
    input  spm_pkg::level_t floor_level,
    input  spm_pkg::coef_t  coef,
    output spm_pkg::level_t result
);

    logic signed [16:0] diff;
    logic signed [16:0] coef_s;
    logic signed [33:0] prod;
    logic signed [17:0] step;
    logic signed [17:0] sum;
    logic signed [17:0] floor_ext;

    assign diff      = {floor_level[15], floor_level} - {value[15], value};
    assign coef_s    = {1'b0, coef};
    assign prod      = diff * coef_s;
    // arithmetic shift gives the floor of prod / 65536
    assign step      = prod[33:16];
    assign sum       = {{2{value[15]}}, value} + step;
    assign floor_ext = {{2{floor_level[15]}}, floor_level};

    always_comb
    begin
        if (sum < floor_ext)
        begin
            result = floor_level;
        end
        else
        begin
            result = sum[15:0];
        end
    end

endmodule

// ===== src/spm_channel.sv =====
// ----------------------------------------------------------------------------
// spm_channel
// Next state of one meter channel: peak hold with decay, clip indicator
// with hysteresis, and displayed level with instant rise and decay.
// ----------------------------------------------------------------------------
module spm_channel
(
    input  spm_pkg::kind_t       kind,
    input  spm_pkg::level_t      level,
    input  spm_pkg::meter_cfg_t  cfg,
    input  spm_pkg::chan_state_t cur,
    output spm_pkg::chan_state_t nxt
);

    spm_pkg::level_t    peak_decayed;
    spm_pkg::level_t    shown_decayed;
    logic signed [16:0] release_level;
    logic               new_peak;
    logic               clip_tick;

    spm_decay u_peak_decay
    (
        .value       (cur.peak),
        .floor_level (cfg.floor_level),
        .coef        (cfg.peak_decay_coef),
        .result      (peak_decayed)
    );

    spm_decay u_shown_decay
    (
        .value       (cur.shown),
        .floor_level (cfg.floor_level),
        .coef        (cfg.display_decay_coef),
        .result      (shown_decayed)
    );

    assign release_level = {cfg.clip_threshold[15], cfg.clip_threshold}
                           - spm_pkg::CLIP_RELEASE;
    assign new_peak      = level > cur.peak;

    always_comb
    begin
        if (new_peak)
        begin
            clip_tick = level >= cfg.clip_threshold;
        end
        else if ($signed({peak_decayed[15], peak_decayed}) < release_level)
        begin
            clip_tick = 1'b0;
        end
        else
        begin
            clip_tick = cur.clip;
        end
    end

    always_comb
    begin
        unique case (kind)
            spm_pkg::KIND_CLEAR:
            begin
                nxt.shown = cfg.floor_level;
                nxt.peak  = cfg.floor_level;
                nxt.clip  = 1'b0;
            end
            default:
            begin
                nxt.peak  = new_peak ? level : peak_decayed;
                nxt.clip  = clip_tick;
                nxt.shown = (level > cur.shown) ? level : shown_decayed;
            end
        endcase
    end

endmodule

// ===== verif/spm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_checker
// Watches the item, result and register channels of the stereo peak meter,
// keeps its own copy of the meter ballistics and of the registers, and
// compares every result with the oldest predicted meter reading.
// ----------------------------------------------------------------------------
module spm_checker
(
    input  logic            clk,
    input  logic            rst_n,

    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            kind,
    input  spm_pkg::level_t left_level,
    input  spm_pkg::level_t right_level,

    input  logic            out_valid,
    input  logic            out_ready,
    input  spm_pkg::level_t left_shown,
    input  spm_pkg::level_t right_shown,
    input  spm_pkg::level_t left_peak,
    input  spm_pkg::level_t right_peak,
    input  logic            left_clip,
    input  logic            right_clip,

    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,

    output int              pending_readings,
    output int              mismatch_count
);

    typedef struct packed {
        spm_pkg::chan_state_t left;
        spm_pkg::chan_state_t right;
    } meter_reading_t;

    spm_pkg::level_t floor_lvl;
    spm_pkg::level_t clip_thr;
    spm_pkg::coef_t  peak_coef;
    spm_pkg::coef_t  shown_coef;

    meter_reading_t meter;
    meter_reading_t readings_q[$];
    int             errors_n = 0;

    task automatic report(input string what);
        $display("%0t ns: %s", $time, what);
        errors_n++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // move a value toward the floor by coef/65536 of its distance, floored
    function automatic spm_pkg::level_t decay_level(spm_pkg::level_t value,
                                                    spm_pkg::coef_t coef);
        longint prod;
        longint nxt;
        prod = (longint'(floor_lvl) - longint'(value)) * longint'(coef);
        nxt  = longint'(value) + (prod >>> 16);
        if (nxt < longint'(floor_lvl))
            nxt = longint'(floor_lvl);
        return spm_pkg::level_t'(nxt);
    endfunction

    function automatic spm_pkg::chan_state_t advance_channel(spm_pkg::chan_state_t st,
                                                             spm_pkg::level_t lvl);
        spm_pkg::level_t pk;
        spm_pkg::level_t sh;
        logic            clp;
        pk  = st.peak;
        sh  = st.shown;
        clp = st.clip;
        if (lvl > pk)
        begin
            pk  = lvl;
            clp = (pk >= clip_thr);
        end
        else
        begin
            pk = decay_level(pk, peak_coef);
            if (int'(pk) < int'(clip_thr) - int'(spm_pkg::CLIP_RELEASE))
                clp = 1'b0;
        end
        if (lvl > sh)
            sh = lvl;
        else
            sh = decay_level(sh, shown_coef);
        return '{shown: sh, peak: pk, clip: clp};
    endfunction

    function automatic spm_pkg::chan_state_t floor_channel();
        return '{shown: floor_lvl, peak: floor_lvl, clip: 1'b0};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        meter_reading_t seen;
        meter_reading_t want;
        if (!rst_n)
        begin
            floor_lvl   = spm_pkg::FLOOR_RESET;
            clip_thr    = spm_pkg::CLIP_THRESH_RESET;
            peak_coef   = spm_pkg::PEAK_COEF_RESET;
            shown_coef  = spm_pkg::DISPLAY_COEF_RESET;
            meter.left  = floor_channel();
            meter.right = floor_channel();
            readings_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (spm_pkg::reg_index_t'(cfg_index))
                    spm_pkg::REG_FLOOR_LEVEL:  floor_lvl  = spm_pkg::level_t'(cfg_data);
                    spm_pkg::REG_CLIP_THRESH:  clip_thr   = spm_pkg::level_t'(cfg_data);
                    spm_pkg::REG_PEAK_COEF:    peak_coef  = spm_pkg::coef_t'(cfg_data);
                    spm_pkg::REG_DISPLAY_COEF: shown_coef = spm_pkg::coef_t'(cfg_data);
                    default:                   ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                seen.left  = '{shown: left_shown,  peak: left_peak,  clip: left_clip};
                seen.right = '{shown: right_shown, peak: right_peak, clip: right_clip};
                if (readings_q.size() == 0)
                    report("result with no item outstanding");
                else
                begin
                    want = readings_q.pop_front();
                    check_field("left_shown",  seen.left.shown,  want.left.shown);
                    check_field("right_shown", seen.right.shown, want.right.shown);
                    check_field("left_peak",   seen.left.peak,   want.left.peak);
                    check_field("right_peak",  seen.right.peak,  want.right.peak);
                    check_field("left_clip",   16'(seen.left.clip),  16'(want.left.clip));
                    check_field("right_clip",  16'(seen.right.clip), 16'(want.right.clip));
                end
            end

            if (in_valid && in_ready)
            begin
                if (spm_pkg::kind_t'(kind) == spm_pkg::KIND_CLEAR)
                begin
                    meter.left  = floor_channel();
                    meter.right = floor_channel();
                end
                else
                begin
                    meter.left  = advance_channel(meter.left,  left_level);
                    meter.right = advance_channel(meter.right, right_level);
                end
                readings_q.push_back(meter);
            end
        end
        pending_readings <= readings_q.size();
        mismatch_count   <= errors_n;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stereo peak meter ballistics block: directed extremes,
// clear items, floor moves and clip hysteresis, then random level ticks under
// several register settings with random idling on both sides, a long result
// hold-off and a full drain mid-run. Checking is done by spm_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int HOLD_CYCLES  = 60;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    logic            clk;
    logic            rst_n;

    logic            in_valid;
    logic            in_ready;
    logic            kind;
    spm_pkg::level_t left_level;
    spm_pkg::level_t right_level;

    logic            out_valid;
    logic            out_ready;
    spm_pkg::level_t left_shown;
    spm_pkg::level_t right_shown;
    spm_pkg::level_t left_peak;
    spm_pkg::level_t right_peak;
    logic            left_clip;
    logic            right_clip;

    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_index;
    logic [15:0]     cfg_data;

    int              pending;
    int              mismatches;

    logic            tx_steady;
    logic            rx_steady;
    logic            hold_req;
    logic            hold_done;
    int              floor_now;
    int              thr_now;

    stereo_peak_meter_ballistics uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .left_level  (left_level),
        .right_level (right_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_shown  (left_shown),
        .right_shown (right_shown),
        .left_peak   (left_peak),
        .right_peak  (right_peak),
        .left_clip   (left_clip),
        .right_clip  (right_clip),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    spm_checker u_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .left_level       (left_level),
        .right_level      (right_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_shown       (left_shown),
        .right_shown      (right_shown),
        .left_peak        (left_peak),
        .right_peak       (right_peak),
        .left_clip        (left_clip),
        .right_clip       (right_clip),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pending_readings (pending),
        .mismatch_count   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic spm_pkg::level_t sat_level(int v);
        if (v > 32767)
            return spm_pkg::level_t'(32767);
        if (v < -32768)
            return spm_pkg::level_t'(-32768);
        return spm_pkg::level_t'(v);
    endfunction

    // bias towards the threshold and the floor so clip and clamp are exercised
    function automatic spm_pkg::level_t pick_level();
        case ($urandom_range(7))
            0:       return spm_pkg::level_t'($urandom);
            1:       return sat_level(thr_now + int'($urandom_range(400)) - 200);
            2:       return sat_level(floor_now + int'($urandom_range(64)) - 32);
            3:       return spm_pkg::level_t'(16'h8000);
            4:       return sat_level(thr_now - int'($urandom_range(3000)));
            default: return sat_level(floor_now - 256 + int'($urandom_range(4096)));
        endcase
    endfunction

    task automatic drive_item(input spm_pkg::kind_t k, input spm_pkg::level_t l,
                              input spm_pkg::level_t r);
        if (!tx_steady)
        begin
            while ($urandom_range(99) < 34)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        kind        <= k;
        left_level  <= l;
        right_level <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold the input until every outstanding reading has come back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input spm_pkg::reg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_config(input spm_pkg::level_t flr, input spm_pkg::level_t thr,
                              input spm_pkg::coef_t pk_coef,
                              input spm_pkg::coef_t sh_coef);
        write_reg(spm_pkg::REG_FLOOR_LEVEL,  flr);
        write_reg(spm_pkg::REG_CLIP_THRESH,  thr);
        write_reg(spm_pkg::REG_PEAK_COEF,    pk_coef);
        write_reg(spm_pkg::REG_DISPLAY_COEF, sh_coef);
        cfg_valid <= 1'b0;
        floor_now = int'(flr);
        thr_now   = int'(thr);
    endtask

    // result side: random stalls, a steady stretch, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= rx_steady || ($urandom_range(99) >= 34);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = spm_pkg::KIND_TICK;
        left_level  = '0;
        right_level = '0;
        cfg_valid   = 1'b0;
        cfg_index   = spm_pkg::REG_FLOOR_LEVEL;
        cfg_data    = '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        hold_req    = 1'b0;
        floor_now   = int'(spm_pkg::FLOOR_RESET);
        thr_now     = int'(spm_pkg::CLIP_THRESH_RESET);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        drive_item(spm_pkg::KIND_TICK,  16'sh7FFF, 16'sh8000);
        drive_item(spm_pkg::KIND_TICK,  16'sh7FFF, 16'sh8000);
        drive_item(spm_pkg::KIND_TICK,  16'sd0,    16'sd0);
        drive_item(spm_pkg::KIND_TICK, -16'sd128, -16'sd129);
        drive_item(spm_pkg::KIND_TICK, -16'sd129, -16'sd15360);
        drive_item(spm_pkg::KIND_CLEAR, 16'sh7FFF, 16'sh7FFF);
        drive_item(spm_pkg::KIND_TICK, -16'sd15360, -16'sd15361);
        drive_item(spm_pkg::KIND_TICK,  16'sh5555, 16'shAAAA);
        drive_item(spm_pkg::KIND_TICK,  16'shAAAA, 16'sh5555);

        // raise the floor
        settle();
        set_config(-16'sd1000, spm_pkg::CLIP_THRESH_RESET, spm_pkg::PEAK_COEF_RESET,
                   spm_pkg::DISPLAY_COEF_RESET);
        drive_item(spm_pkg::KIND_TICK,  16'sh8000, 16'sh8000);
        drive_item(spm_pkg::KIND_TICK, -16'sd999,  16'sh8000);

        // full-scale coefficients, floor at zero
        settle();
        set_config(16'sd0, 16'sh7FFF, 16'hFFFF, 16'hFFFF);
        drive_item(spm_pkg::KIND_TICK,  16'sh7FFF, 16'sd100);
        drive_item(spm_pkg::KIND_TICK, -16'sd5,   -16'sd5);
        drive_item(spm_pkg::KIND_TICK,  16'sh8000, 16'sh8000);

        // zero coefficients hold, lowest floor and threshold
        settle();
        set_config(16'sh8000, 16'sh8000, 16'h0000, 16'h0000);
        drive_item(spm_pkg::KIND_TICK,  16'sd10,   16'sh8000);
        drive_item(spm_pkg::KIND_TICK,  16'sh8000, 16'sh8000);
        drive_item(spm_pkg::KIND_CLEAR, 16'sh0000, 16'shFFFF);
        drive_item(spm_pkg::KIND_TICK,  16'sh8000, 16'sh8001);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: set_config(spm_pkg::FLOOR_RESET, spm_pkg::CLIP_THRESH_RESET,
                              spm_pkg::PEAK_COEF_RESET, spm_pkg::DISPLAY_COEF_RESET);
                1: set_config(16'sh8000, 16'sh7FFF, 16'hFFFF, 16'hFFFF);
                2: set_config(16'sd0, 16'sh8000, 16'h0000, 16'h0000);
                4: set_config(16'sd256, 16'sd1000, spm_pkg::coef_t'($urandom),
                              spm_pkg::coef_t'($urandom));
                default: set_config(spm_pkg::level_t'(-int'($urandom_range(32768))),
                                    spm_pkg::level_t'($urandom),
                                    spm_pkg::coef_t'($urandom_range(8000)),
                                    spm_pkg::coef_t'($urandom));
            endcase
            tx_steady = (ph == 2 || ph == 3);
            rx_steady = (ph == 3);
            if (ph == 2)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    settle();
                if ($urandom_range(99) < 3)
                    drive_item(spm_pkg::KIND_CLEAR, spm_pkg::level_t'($urandom),
                               spm_pkg::level_t'($urandom));
                else
                    drive_item(spm_pkg::KIND_TICK, pick_level(), pick_level());
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
